[hdl/pvpu_pkg.sv]
// Shared types and constants of the particle swarm velocity and position update.
`timescale 1ns / 1ps

package pvpu_pkg;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_WEIGHT_MODE     = 4'd0,
    REG_ACCEL_MODE      = 4'd1,
    REG_INERTIA_WEIGHT  = 4'd2,
    REG_ACCEL_COEFF     = 4'd3,
    REG_VEL_LIMIT       = 4'd4,
    REG_POS_LIMIT       = 4'd5,
    REG_RUN_LENGTH      = 4'd6,
    REG_USE_GLOBAL_BEST = 4'd7
  } reg_idx_e;

  // Configuration register file contents.
  typedef struct packed {
    logic        weight_mode;
    logic        accel_mode;
    logic [15:0] inertia_weight;
    logic [15:0] accel_coeff;
    logic [30:0] vel_limit;
    logic [30:0] pos_limit;
    logic [15:0] run_length;
    logic        use_global_best;
  } cfg_t;

  // Coefficients from the schedule unit, all unsigned Q4.12.
  typedef struct packed {
    logic [15:0] w;
    logic [15:0] c1;
    logic [15:0] c2;
  } coef_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_INERTIA_WEIGHT = 16'd2949;
  localparam logic [15:0] RST_ACCEL_COEFF    = 16'd6144;
  localparam logic [30:0] RST_VEL_LIMIT      = 31'd65536;
  localparam logic [30:0] RST_POS_LIMIT      = 31'd6553600;
  localparam logic [15:0] RST_RUN_LENGTH     = 16'd1000;

  // Coefficient end points in Q4.12: 2.5 and 0.5.
  localparam logic [15:0] C_HIGH = 16'd10240;
  localparam logic [15:0] C_LOW  = 16'd2048;

  // Quotient bits resolved by the schedule dividers, one per stage.
  localparam int DIV_STEPS   = 14;
  // Schedule latency: entry register, divider stages, output register.
  localparam int SCHED_LAT   = DIV_STEPS + 2;
  // Arithmetic stages after the schedule: phi, products, sum, clamps.
  localparam int MATH_STAGES = 5;
  localparam int PIPE_LAT    = SCHED_LAT + MATH_STAGES;

endpackage

[hdl/pso_velocity_position_update.sv]
// Top level of the particle swarm velocity and position update pipeline.
//
//  Channel   | Handshake                  | Word
//  ----------+----------------------------+--------------------------------------------
//  input     | start high, busy low       | position, velocity, bests, iteration, rands
//  result    | done_o strobe, one cycle   | new_position, new_velocity, clamp flags
//  config    | cfg_valid_i & cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while busy is low; each result then passes through
// the 14-stage schedule dividers plus the multiply, sum and clamp stages.
// Reset is asynchronous and active low; busy is set by it and registered low after it.
// The pipeline advances every cycle, so results leave in order with no stall.
`timescale 1ns / 1ps

module pso_velocity_position_update import pvpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] velocity_i,
  input  logic signed [31:0] personal_best_i,
  input  logic signed [31:0] local_best_i,
  input  logic signed [31:0] global_best_i,
  input  logic [15:0]        iteration_i,
  input  logic [15:0]        rand_one_i,
  input  logic [15:0]        rand_two_i,
  input  logic               last_in_i,
  // Result channel
  output logic               done_o,
  output logic signed [31:0] new_position_o,
  output logic signed [31:0] new_velocity_o,
  output logic               vel_clamped_o,
  output logic               pos_clamped_o,
  output logic               last_out_o,
  // Configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // Operand word carried alongside the schedule unit.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] v;
    logic signed [32:0] dp;
    logic signed [32:0] dg;
    logic [15:0]        r1;
    logic [15:0]        r2;
    logic               last;
  } opnd_t;

  logic accept;
  logic busy_q;

  // Busy only while coming out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start & ~busy_q;

  // Configuration registers.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_mode     <= 1'b0;
      cfg_q.accel_mode      <= 1'b0;
      cfg_q.inertia_weight  <= RST_INERTIA_WEIGHT;
      cfg_q.accel_coeff     <= RST_ACCEL_COEFF;
      cfg_q.vel_limit       <= RST_VEL_LIMIT;
      cfg_q.pos_limit       <= RST_POS_LIMIT;
      cfg_q.run_length      <= RST_RUN_LENGTH;
      cfg_q.use_global_best <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_WEIGHT_MODE:     cfg_q.weight_mode     <= cfg_data_i[0];
        REG_ACCEL_MODE:      cfg_q.accel_mode      <= cfg_data_i[0];
        REG_INERTIA_WEIGHT:  cfg_q.inertia_weight  <= cfg_data_i[15:0];
        REG_ACCEL_COEFF:     cfg_q.accel_coeff     <= cfg_data_i[15:0];
        REG_VEL_LIMIT:       cfg_q.vel_limit       <= cfg_data_i[30:0];
        REG_POS_LIMIT:       cfg_q.pos_limit       <= cfg_data_i[30:0];
        REG_RUN_LENGTH:      cfg_q.run_length      <= cfg_data_i[15:0];
        REG_USE_GLOBAL_BEST: cfg_q.use_global_best <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Valid bits, one per stage.
  logic vld_q [PIPE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Entry: guide selection and the two position differences.
  opnd_t entry;

  always_comb begin
    entry.x    = position_i;
    entry.v    = velocity_i;
    entry.dp   = {personal_best_i[31], personal_best_i} - {position_i[31], position_i};
    entry.dg   = cfg_q.use_global_best
               ? ({global_best_i[31], global_best_i} - {position_i[31], position_i})
               : ({local_best_i[31], local_best_i} - {position_i[31], position_i});
    entry.r1   = rand_one_i;
    entry.r2   = rand_two_i;
    entry.last = last_in_i;
  end

  // Operand delay line matched to the schedule latency.
  opnd_t opnd_q [SCHED_LAT];

  always_ff @(posedge clk_i) begin
    opnd_q[0] <= entry;
    for (int i = 1; i < SCHED_LAT; i++) begin
      opnd_q[i] <= opnd_q[i-1];
    end
  end

  coef_t coef;

  pvpu_sched u_sched (
    .clk_i       (clk_i),
    .cfg_i       (cfg_q),
    .iteration_i (iteration_i),
    .coef_o      (coef)
  );

  // Stage A: random scaling of the acceleration coefficients.
  logic signed [31:0] a_x_q;
  logic signed [31:0] a_v_q;
  logic signed [32:0] a_dp_q;
  logic signed [32:0] a_dg_q;
  logic [15:0]        a_w_q;
  logic [19:0]        a_phi1_q;
  logic [19:0]        a_phi2_q;
  logic               a_last_q;
  logic [31:0]        prod1;
  logic [31:0]        prod2;

  assign prod1 = {16'b0, coef.c1} * {16'b0, opnd_q[SCHED_LAT-1].r1};
  assign prod2 = {16'b0, coef.c2} * {16'b0, opnd_q[SCHED_LAT-1].r2};

  always_ff @(posedge clk_i) begin
    a_x_q    <= opnd_q[SCHED_LAT-1].x;
    a_v_q    <= opnd_q[SCHED_LAT-1].v;
    a_dp_q   <= opnd_q[SCHED_LAT-1].dp;
    a_dg_q   <= opnd_q[SCHED_LAT-1].dg;
    a_w_q    <= coef.w;
    a_phi1_q <= prod1[31:12];
    a_phi2_q <= prod2[31:12];
    a_last_q <= opnd_q[SCHED_LAT-1].last;
  end

  // Stage B: the three products, exact.
  logic signed [31:0] b_x_q;
  logic signed [48:0] b_pv_q;
  logic signed [53:0] b_p1_q;
  logic signed [53:0] b_p2_q;
  logic               b_last_q;

  always_ff @(posedge clk_i) begin
    b_x_q    <= a_x_q;
    b_pv_q   <= $signed({{17{a_v_q[31]}}, a_v_q}) * $signed({32'b0, a_w_q});
    b_p1_q   <= $signed({{21{a_dp_q[32]}}, a_dp_q}) * $signed({33'b0, a_phi1_q});
    b_p2_q   <= $signed({{21{a_dg_q[32]}}, a_dg_q}) * $signed({33'b0, a_phi2_q});
    b_last_q <= a_last_q;
  end

  // Stage C: round each product to Q16.16 (halves up) and add.
  logic signed [48:0] pv_rnd;
  logic signed [53:0] p1_rnd;
  logic signed [53:0] p2_rnd;
  logic signed [39:0] sum_d;
  logic signed [31:0] c_x_q;
  logic signed [39:0] c_nv_q;
  logic               c_last_q;

  always_comb begin
    pv_rnd = b_pv_q + 49'sd2048;
    p1_rnd = b_p1_q + 54'sd32768;
    p2_rnd = b_p2_q + 54'sd32768;
    sum_d  = $signed({{3{pv_rnd[48]}}, pv_rnd[48:12]})
           + $signed({{2{p1_rnd[53]}}, p1_rnd[53:16]})
           + $signed({{2{p2_rnd[53]}}, p2_rnd[53:16]});
  end

  always_ff @(posedge clk_i) begin
    c_x_q    <= b_x_q;
    c_nv_q   <= sum_d;
    c_last_q <= b_last_q;
  end

  // Stage D: velocity clamp.
  logic signed [39:0] vel_lim;
  logic signed [31:0] nv_d;
  logic               vc_d;
  logic signed [31:0] d_x_q;
  logic signed [31:0] d_nv_q;
  logic               d_vc_q;
  logic               d_last_q;

  always_comb begin
    vel_lim = $signed({9'b0, cfg_q.vel_limit});
    nv_d    = c_nv_q[31:0];
    vc_d    = 1'b0;
    priority if (c_nv_q > vel_lim) begin
      nv_d = vel_lim[31:0];
      vc_d = 1'b1;
    end else if (c_nv_q < -vel_lim) begin
      nv_d = 32'(-vel_lim);
      vc_d = 1'b1;
    end else begin
      nv_d = c_nv_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    d_x_q    <= c_x_q;
    d_nv_q   <= nv_d;
    d_vc_q   <= vc_d;
    d_last_q <= c_last_q;
  end

  // Stage E: position update and clamp into the result register.
  logic signed [32:0] nx;
  logic signed [32:0] pos_lim;
  logic signed [31:0] pos_d;
  logic signed [31:0] vel_d;
  logic               pc_d;
  logic signed [31:0] out_pos_q;
  logic signed [31:0] out_vel_q;
  logic               out_vc_q;
  logic               out_pc_q;
  logic               out_last_q;

  always_comb begin
    nx      = {d_x_q[31], d_x_q} + {d_nv_q[31], d_nv_q};
    pos_lim = $signed({2'b0, cfg_q.pos_limit});
    pos_d   = nx[31:0];
    vel_d   = d_nv_q;
    pc_d    = 1'b0;
    priority if (nx > pos_lim) begin
      pos_d = pos_lim[31:0];
      vel_d = '0;
      pc_d  = 1'b1;
    end else if (nx < -pos_lim) begin
      pos_d = 32'(-pos_lim);
      vel_d = '0;
      pc_d  = 1'b1;
    end else begin
      pos_d = nx[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_pos_q  <= pos_d;
    out_vel_q  <= vel_d;
    out_vc_q   <= d_vc_q;
    out_pc_q   <= pc_d;
    out_last_q <= d_last_q;
  end

  assign done_o         = vld_q[PIPE_LAT-1];
  assign new_position_o = out_pos_q;
  assign new_velocity_o = out_vel_q;
  assign vel_clamped_o  = out_vc_q;
  assign pos_clamped_o  = out_pc_q;
  assign last_out_o     = out_last_q;

endmodule

[hdl/pvpu_sched.sv]
// Pipelined schedule unit: inertia weight and acceleration coefficients per item.
`timescale 1ns / 1ps

module pvpu_sched import pvpu_pkg::*; (
  input  logic        clk_i,
  input  cfg_t        cfg_i,
  input  logic [15:0] iteration_i,
  output coef_t       coef_o
);

  // Divisors follow from run_length, which the user must hold still while items are in flight (not enforced).
  logic [15:0] run_t;
  logic [18:0] five_t;
  logic [15:0] it_clip;
  logic [15:0] it_left;
  logic [29:0] num_d;
  logic [30:0] num_w;

  always_comb begin
    run_t   = (cfg_i.run_length == '0) ? 16'd1 : cfg_i.run_length;
    five_t  = {3'b0, run_t} + {1'b0, run_t, 2'b0};
    it_clip = (iteration_i > run_t) ? run_t : iteration_i;
    it_left = run_t - it_clip;
    // Coefficient shift numerator: 8192*it + floor(T/2).
    num_d   = {1'b0, it_clip, 13'b0} + {15'b0, run_t[15:1]};
    // Weight numerator: 8192*T + 10240*(T - it) + floor(5T/2).
    num_w   = {2'b0, run_t, 13'b0} + {2'b0, it_left, 13'b0}
            + {4'b0, it_left, 11'b0} + {13'b0, five_t[18:1]};
  end

  // Remainders and partial quotients of the two restoring dividers.
  logic [29:0]          rem_d_q [DIV_STEPS+1];
  logic [30:0]          rem_w_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_d_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_w_q [DIV_STEPS+1];

  // Entry stage.
  always_ff @(posedge clk_i) begin
    rem_d_q[0] <= num_d;
    rem_w_q[0] <= num_w;
    quo_d_q[0] <= '0;
    quo_w_q[0] <= '0;
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int Bit = DIV_STEPS - 1 - k;

    logic [31:0]          dvs_d;
    logic [31:0]          dvs_w;
    logic [31:0]          ext_d;
    logic [31:0]          ext_w;
    logic [29:0]          rem_d_d;
    logic [30:0]          rem_w_d;
    logic [DIV_STEPS-1:0] quo_d_d;
    logic [DIV_STEPS-1:0] quo_w_d;

    always_comb begin
      dvs_d   = {16'b0, run_t} << Bit;
      dvs_w   = {13'b0, five_t} << Bit;
      ext_d   = {2'b0, rem_d_q[k]};
      ext_w   = {1'b0, rem_w_q[k]};
      rem_d_d = rem_d_q[k];
      rem_w_d = rem_w_q[k];
      quo_d_d = quo_d_q[k];
      quo_w_d = quo_w_q[k];
      if (ext_d >= dvs_d) begin
        rem_d_d      = 30'(ext_d - dvs_d);
        quo_d_d[Bit] = 1'b1;
      end
      if (ext_w >= dvs_w) begin
        rem_w_d      = 31'(ext_w - dvs_w);
        quo_w_d[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_d_q[k+1] <= rem_d_d;
      rem_w_q[k+1] <= rem_w_d;
      quo_d_q[k+1] <= quo_d_d;
      quo_w_q[k+1] <= quo_w_d;
    end
  end

  // Mode selection and coefficient forming.
  coef_t coef_d;
  coef_t coef_q;

  always_comb begin
    if (cfg_i.weight_mode) begin
      coef_d.w = {2'b0, quo_w_q[DIV_STEPS]};
    end else begin
      coef_d.w = cfg_i.inertia_weight;
    end
    if (cfg_i.accel_mode) begin
      coef_d.c1 = C_HIGH - {2'b0, quo_d_q[DIV_STEPS]};
      coef_d.c2 = C_LOW + {2'b0, quo_d_q[DIV_STEPS]};
    end else begin
      coef_d.c1 = cfg_i.accel_coeff;
      coef_d.c2 = cfg_i.accel_coeff;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule

[hdl/pvpu_checker.sv]
// Port-level checker for the velocity and position update, bound to the top level.
`timescale 1ns / 1ps

module pvpu_checker import pvpu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               last_in_i,
  input logic               done_o,
  input logic signed [31:0] new_velocity_o,
  input logic               pos_clamped_o,
  input logic               last_out_o
);

  localparam int CntW = $clog2(PIPE_LAT + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(PIPE_LAT);

  // Cycles since reset, saturating at the pipeline latency.
  logic [CntW-1:0] since_rst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_rst_q <= '0;
    end else if (since_rst_q != CntMax) begin
      since_rst_q <= since_rst_q + 1'b1;
    end
  end

  // Every result goes back to a word accepted earlier, at the pipeline latency.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without an accepted word");

  // Every accepted word yields its result once the pipeline ran reset-free.
  a_word_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (since_rst_q == CntMax && $past(start && !busy, PIPE_LAT)) |-> done_o)
    else $error("accepted word produced no result");

  // The particle end marker travels with its word.
  a_last_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> last_out_o == $past(last_in_i, PIPE_LAT))
    else $error("end marker out of step with its word");

  // A position clamp always zeroes the velocity.
  a_clamp_zeroes_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pos_clamped_o) |-> new_velocity_o == '0)
    else $error("position clamped with nonzero velocity");

endmodule

bind pso_velocity_position_update pvpu_checker u_pvpu_checker (.*);
